// File: rtl/windowed_peak_to_peak_monitor_defines.svh
// Assertion macros shared by the RTL.
`ifndef WINDOWED_PEAK_TO_PEAK_MONITOR_DEFINES_SVH
`define WINDOWED_PEAK_TO_PEAK_MONITOR_DEFINES_SVH

// Check prop on every clock edge outside reset.
`define WPPM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check prop on every clock edge, reset included.
`define WPPM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/wppm_pkg.sv
package wppm_pkg;

   localparam int TIME_W   = 32;
   localparam int LEVEL_W  = 12;
   localparam int WINDOW_W = 16;
   localparam int COUNT_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd3000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPREAD_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_THRESHOLD  = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0]  time_ms;
      logic [LEVEL_W-1:0] level_a;
      logic [LEVEL_W-1:0] level_b;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] window_max;
      logic [LEVEL_W-1:0] window_min;
      logic [LEVEL_W-1:0] spread;
      logic               change_led;
      logic [COUNT_W-1:0] change_count;
      logic [COUNT_W-1:0] crossing_count;
      logic               above_level;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]  time_ms;
      logic [LEVEL_W-1:0] level;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctl_type;

   typedef struct packed {
      logic               found;
      logic [LEVEL_W-1:0] hi;
      logic [LEVEL_W-1:0] lo;
   } scan_res_type;

endpackage

// File: rtl/wppm_cell.sv
module wppm_cell (
   input  logic                clock,
   input  logic                shift,
   input  wppm_pkg::entry_type d,
   output wppm_pkg::entry_type q
);

   wppm_pkg::entry_type entry_ff;
   wppm_pkg::entry_type entry_in;

   always_comb begin
      entry_in = shift ? d : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

// File: rtl/wppm_scan.sv
module wppm_scan #(
   parameter int CNT_W = 5
) (
   input  logic                          clock,
   input  wppm_pkg::scan_ctl_type        ctl,
   input  wppm_pkg::entry_type           tail,
   input  logic [wppm_pkg::TIME_W-1:0]   now,
   input  logic [wppm_pkg::WINDOW_W-1:0] window_ms,
   input  logic [CNT_W-1:0]              pos,
   input  logic [CNT_W-1:0]              count,
   output wppm_pkg::scan_res_type        res,
   output logic [CNT_W-1:0]              keep
);

   logic                          found_ff, found_in;
   logic [wppm_pkg::LEVEL_W-1:0]  hi_ff, hi_in, lo_ff, lo_in;
   logic [CNT_W-1:0]              keep_ff, keep_in;
   logic [wppm_pkg::TIME_W-1:0]   age;
   logic                          live;

   always_comb begin
      age  = now - tail.time_ms;
      // Skip expired entries only until the first live one is found.
      live = (pos < count) &&
             (found_ff || (age <= {{(wppm_pkg::TIME_W-wppm_pkg::WINDOW_W){1'b0}}, window_ms}));
      found_in = found_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      keep_in  = keep_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.step && live) begin
         found_in = 1'b1;
         if (!found_ff) begin
            hi_in   = tail.level;
            lo_in   = tail.level;
            keep_in = pos + CNT_W'(1);
         end else begin
            if (tail.level > hi_ff) hi_in = tail.level;
            if (tail.level < lo_ff) lo_in = tail.level;
         end
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      keep_ff  <= keep_in;
   end

   assign res.found = found_ff;
   assign res.hi    = hi_ff;
   assign res.lo    = lo_ff;
   assign keep      = keep_ff;

endmodule

// File: rtl/windowed_peak_to_peak_monitor.sv
// Windowed peak-to-peak monitor.
// req channel: one word per sample pair (timestamp, level A, level B).
// rsp channel: one word per accepted req word with window max/min, spread,
// change indicator and counters, all after the update.
// csr channel: register writes (window, spread threshold, level threshold),
// always ready; write only while no word is in flight.
// Level A entries sit in a row of DEPTH-1 cells. On accept the row shifts
// the new entry in; it then rotates once around its whole length, one cell
// per cycle, while the tail cell feeds the expiry and max/min tracker.
// After the accept the row rotates in ST_SCAN, then ST_FINISH loads the result
// into the output register; no new word is taken until the state is back in
// ST_IDLE, and req_ready is high again the cycle after the result is loaded.
// The result sits in an output register; a new word can be taken while it
// waits. If the receiver still stalls when the next result is ready, the
// block holds in its final state until rsp_ready.
// Reset clears counters, flags, the entry count and the registers (window
// 3000 ms, thresholds 0); cell contents are left as they are.
`include "windowed_peak_to_peak_monitor_defines.svh"

module windowed_peak_to_peak_monitor #(
   parameter int DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  wppm_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output wppm_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wppm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wppm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CELLS = DEPTH - 1;
   localparam int CNT_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] LAST_POS  = CNT_W'(CELLS - 1);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(CELLS);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [wppm_pkg::WINDOW_W-1:0] window_ff, window_in;
   logic [wppm_pkg::LEVEL_W-1:0]  spread_thr_ff, spread_thr_in;
   logic [wppm_pkg::LEVEL_W-1:0]  level_thr_ff, level_thr_in;

   logic [wppm_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [wppm_pkg::LEVEL_W-1:0]  level_b_ff, level_b_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              pos_ff, pos_in;

   logic                          stable_ff, stable_in;
   logic                          led_ff, led_in;
   logic [wppm_pkg::COUNT_W-1:0]  change_cnt_ff, change_cnt_in;
   logic [wppm_pkg::COUNT_W-1:0]  cross_cnt_ff, cross_cnt_in;
   logic                          above_ff, above_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   wppm_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                          req_accept;
   logic                          csr_write;
   logic                          load_rsp;
   logic                          row_shift;
   wppm_pkg::entry_type           head_d;
   wppm_pkg::entry_type           row_q [CELLS];
   wppm_pkg::scan_ctl_type        scan_ctl;
   wppm_pkg::scan_res_type        scan_res;
   logic [CNT_W-1:0]              scan_keep;
   logic [wppm_pkg::LEVEL_W-1:0]  spread;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign load_rsp   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Insert on accept, rotate tail back to head while scanning.
   assign row_shift = req_accept || (state_ff == ST_SCAN);
   always_comb begin
      if (state_ff == ST_IDLE) begin
         head_d.time_ms = req_data.time_ms;
         head_d.level   = req_data.level_a;
      end else begin
         head_d = row_q[CELLS-1];
      end
   end

   for (genvar k = 0; k < CELLS; k++) begin : g_row
      if (k == 0) begin : g_head
         wppm_cell u_cell (
            .clock (clock),
            .shift (row_shift),
            .d     (head_d),
            .q     (row_q[k])
         );
      end else begin : g_body
         wppm_cell u_cell (
            .clock (clock),
            .shift (row_shift),
            .d     (row_q[k-1]),
            .q     (row_q[k])
         );
      end
   end

   assign scan_ctl.clear = req_accept;
   assign scan_ctl.step  = (state_ff == ST_SCAN);

   wppm_scan #(
      .CNT_W (CNT_W)
   ) u_scan (
      .clock     (clock),
      .ctl       (scan_ctl),
      .tail      (row_q[CELLS-1]),
      .now       (now_ff),
      .window_ms (window_ff),
      .pos       (pos_ff),
      .count     (count_ff),
      .res       (scan_res),
      .keep      (scan_keep)
   );

   assign spread = scan_res.hi - scan_res.lo;

   always_comb begin
      state_in      = state_ff;
      window_in     = window_ff;
      spread_thr_in = spread_thr_ff;
      level_thr_in  = level_thr_ff;
      now_in        = now_ff;
      level_b_in    = level_b_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      stable_in     = stable_ff;
      led_in        = led_ff;
      change_cnt_in = change_cnt_ff;
      cross_cnt_in  = cross_cnt_ff;
      above_in      = above_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      if (csr_write) begin
         unique case (csr_index)
            wppm_pkg::CSR_WINDOW_MS:        window_in = csr_wdata;
            wppm_pkg::CSR_SPREAD_THRESHOLD: spread_thr_in = csr_wdata[wppm_pkg::LEVEL_W-1:0];
            wppm_pkg::CSR_LEVEL_THRESHOLD:  level_thr_in = csr_wdata[wppm_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               now_in     = req_data.time_ms;
               level_b_in = req_data.level_b;
               // full row drops its oldest entry
               if (count_ff != MAX_COUNT) count_in = count_ff + CNT_W'(1);
               pos_in   = LAST_POS;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pos_in = pos_ff - CNT_W'(1);
            if (pos_ff == '0) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_rsp) begin
               count_in = scan_keep;
               if (spread < spread_thr_ff) begin
                  stable_in = 1'b1;
                  led_in    = 1'b0;
               end else if (stable_ff) begin
                  stable_in     = 1'b0;
                  change_cnt_in = change_cnt_ff + wppm_pkg::COUNT_W'(1);
               end
               if (spread > spread_thr_ff) led_in = 1'b1;

               if (level_b_ff > level_thr_ff && !above_ff) begin
                  cross_cnt_in = cross_cnt_ff + wppm_pkg::COUNT_W'(1);
                  above_in     = 1'b1;
               end else if (level_b_ff < level_thr_ff && above_ff) begin
                  above_in = 1'b0;
               end

               rsp_valid_in               = 1'b1;
               rsp_data_in.window_max     = scan_res.hi;
               rsp_data_in.window_min     = scan_res.lo;
               rsp_data_in.spread         = spread;
               rsp_data_in.change_led     = led_in;
               rsp_data_in.change_count   = change_cnt_in;
               rsp_data_in.crossing_count = cross_cnt_in;
               rsp_data_in.above_level    = above_in;
               state_in                   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_ff     <= wppm_pkg::WINDOW_RESET;
         spread_thr_ff <= '0;
         level_thr_ff  <= '0;
         count_ff      <= '0;
         pos_ff        <= '0;
         stable_ff     <= 1'b0;
         led_ff        <= 1'b0;
         change_cnt_ff <= '0;
         cross_cnt_ff  <= '0;
         above_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_ff     <= window_in;
         spread_thr_ff <= spread_thr_in;
         level_thr_ff  <= level_thr_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         stable_ff     <= stable_in;
         led_ff        <= led_in;
         change_cnt_ff <= change_cnt_in;
         cross_cnt_ff  <= cross_cnt_in;
         above_ff      <= above_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      level_b_ff  <= level_b_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `WPPM_ASSERT(a_accept_starts_scan, clock, reset, req_accept |=> (state_ff == ST_SCAN) && (pos_ff == LAST_POS), "accepted word did not start a full scan")
   `WPPM_ASSERT(a_newest_always_live, clock, reset, (state_ff == ST_FINISH) |-> scan_res.found, "scan ended without a live entry")
   `WPPM_ASSERT(a_keep_in_range, clock, reset, (state_ff == ST_FINISH) |-> (scan_keep != '0) && (scan_keep <= count_ff), "kept entry count out of range")
   `WPPM_ASSERT(a_load_shows_result, clock, reset, load_rsp |=> rsp_valid_ff && (state_ff == ST_IDLE), "loaded result not presented")
   `WPPM_ASSERT_ALWAYS(a_count_bounded, clock, reset || (count_ff <= MAX_COUNT), "entry count exceeds row length")

endmodule

// File: tb/sv/windowed_peak_to_peak_checker.sv
`timescale 1ns / 100ps

module windowed_peak_to_peak_checker
   import wppm_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    awaiting
);

   // register copies
   logic [WINDOW_W-1:0] window_limit;
   logic [LEVEL_W-1:0]  spread_limit;
   logic [LEVEL_W-1:0]  crossing_level;

   // window contents and tracking state
   logic [TIME_W-1:0]  stamp_ring [DEPTH];
   logic [LEVEL_W-1:0] sample_ring[DEPTH];
   int                 head;
   int                 tail;
   logic               calm;
   logic               led;
   logic [COUNT_W-1:0] change_total;
   logic [COUNT_W-1:0] crossing_total;
   logic               above;

   rsp_type            window_reports[$];
   rsp_type            oldest_report;

   // Insert the sample, expire old entries, rescan the window and update flags.
   function automatic rsp_type advance_window(req_type w);
      rsp_type            r;
      logic [LEVEL_W-1:0] hi;
      logic [LEVEL_W-1:0] lo;
      logic [LEVEL_W-1:0] spread;
      logic [TIME_W-1:0]  age;
      int                 i;
      int                 n;
      stamp_ring[head] = w.time_ms;
      sample_ring[head] = w.level_a;
      head = (head + 1) % DEPTH;
      // full ring: drop the oldest entry
      if (head == tail) begin
         tail = (tail + 1) % DEPTH;
      end
      n = 0;
      age = w.time_ms - stamp_ring[tail];
      while (n < DEPTH && age > TIME_W'(window_limit)) begin
         tail = (tail + 1) % DEPTH;
         age = w.time_ms - stamp_ring[tail];
         n++;
      end
      hi = sample_ring[tail];
      lo = hi;
      i = tail;
      while (i != head) begin
         if (sample_ring[i] > hi) hi = sample_ring[i];
         if (sample_ring[i] < lo) lo = sample_ring[i];
         i = (i + 1) % DEPTH;
      end
      spread = hi - lo;
      if (spread < spread_limit) begin
         calm = 1'b1;
         led = 1'b0;
      end else if (calm) begin
         calm = 1'b0;
         change_total = change_total + 1'b1;
      end
      if (spread > spread_limit) begin
         led = 1'b1;
      end
      if (w.level_b > crossing_level && !above) begin
         crossing_total = crossing_total + 1'b1;
         above = 1'b1;
      end else if (w.level_b < crossing_level && above) begin
         above = 1'b0;
      end
      r.window_max = hi;
      r.window_min = lo;
      r.spread = spread;
      r.change_led = led;
      r.change_count = change_total;
      r.crossing_count = crossing_total;
      r.above_level = above;
      return r;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_limit = WINDOW_RESET;
         spread_limit = '0;
         crossing_level = '0;
         head = 0;
         tail = 0;
         calm = 1'b0;
         led = 1'b0;
         change_total = '0;
         crossing_total = '0;
         above = 1'b0;
         window_reports.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_MS:        window_limit = csr_wdata[WINDOW_W-1:0];
               CSR_SPREAD_THRESHOLD: spread_limit = csr_wdata[LEVEL_W-1:0];
               CSR_LEVEL_THRESHOLD:  crossing_level = csr_wdata[LEVEL_W-1:0];
               default: ;
            endcase
         end
         // compare the result word before queueing a new sample word
         if (rsp_valid && rsp_ready) begin
            if (window_reports.size() == 0) begin
               $error("rsp word arrived with nothing expected");
               fail_count++;
            end else begin
               oldest_report = window_reports.pop_front();
               check_field("window_max", oldest_report.window_max, rsp_data.window_max);
               check_field("window_min", oldest_report.window_min, rsp_data.window_min);
               check_field("spread", oldest_report.spread, rsp_data.spread);
               check_field("change_led", oldest_report.change_led, rsp_data.change_led);
               check_field("change_count", oldest_report.change_count,
                           rsp_data.change_count);
               check_field("crossing_count", oldest_report.crossing_count,
                           rsp_data.crossing_count);
               check_field("above_level", oldest_report.above_level, rsp_data.above_level);
            end
         end
         if (req_valid && req_ready) begin
            window_reports.push_back(advance_window(req_data));
         end
      end
      awaiting = window_reports.size();
   end

endmodule

// File: tb/sv/tb_windowed_peak_to_peak_monitor.sv
`timescale 1ns / 100ps

module tb_windowed_peak_to_peak_monitor;
   import wppm_pkg::*;

   localparam int DEPTH = 32;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;
   localparam int PHASES = 8;
   localparam int PHASE_WORDS = 250;
   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                    fail_count;
   int                    awaiting;
   int                    cycle_count = 0;
   bit                    steady;
   logic [TIME_W-1:0]     stamp_now;
   int                    cur_window;
   int                    cur_spread;
   int                    cur_level;

   windowed_peak_to_peak_monitor #(.DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   windowed_peak_to_peak_checker #(.DEPTH(DEPTH)) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .awaiting(awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stall per word, none while steady
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic req_type make_word(logic [TIME_W-1:0] stamp, int a, int b);
      req_type w;
      w.time_ms = stamp;
      w.level_a = LEVEL_W'(a);
      w.level_b = LEVEL_W'(b);
      return w;
   endfunction

   function automatic int clamp_level(int v);
      if (v < 0) return 0;
      if (v > LEVEL_MAX) return LEVEL_MAX;
      return v;
   endfunction

   // Leave valid high on return so a following word can go out without a gap.
   task automatic send_word(req_type w);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold the sender until every result has come, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(int win, int spr, int lvl);
      csr_write(CSR_UNUSED, CSR_DATA_W'($urandom()));
      csr_write(CSR_WINDOW_MS, CSR_DATA_W'(win));
      // upper data bits are junk the block must drop
      csr_write(CSR_SPREAD_THRESHOLD, {4'($urandom()), LEVEL_W'(spr)});
      csr_write(CSR_LEVEL_THRESHOLD, {4'($urandom()), LEVEL_W'(lvl)});
      csr_valid <= 1'b0;
      cur_window = win;
      cur_spread = spr;
      cur_level = lvl;
   endtask

   // Mostly advancing timestamps with clustered levels; a few stray stamps.
   task automatic random_phase(int count);
      int                amp;
      int                center;
      int                a;
      int                b;
      int                roll;
      int                k;
      logic [TIME_W-1:0] stamp;
      amp = 0;
      center = 0;
      for (k = 0; k < count; k++) begin
         if (k % 32 == 0) begin
            center = $urandom_range(0, LEVEL_MAX);
            case ($urandom_range(0, 4))
               0: amp = 0;
               1: amp = cur_spread / 2;
               2: amp = cur_spread;
               3: amp = cur_spread + 1;
               default: amp = LEVEL_MAX;
            endcase
         end
         if (k % 64 == 0) begin
            steady = ($urandom_range(0, 4) == 0);
         end
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            stamp = $urandom();
         end else begin
            if (roll >= 85) begin
               stamp_now += $urandom_range(0, cur_window * 2 + 2);
            end else if (roll >= 25) begin
               stamp_now += $urandom_range(0, cur_window / 16 + 1);
            end
            stamp = stamp_now;
         end
         a = clamp_level(center - amp / 2 + int'($urandom_range(0, amp)));
         if ($urandom_range(0, 99) < 3) begin
            a = $urandom_range(0, 1) * LEVEL_MAX;
         end
         if ($urandom_range(0, 9) < 7) begin
            b = clamp_level(cur_level + int'($urandom_range(0, 6)) - 3);
         end else begin
            b = $urandom_range(0, LEVEL_MAX);
         end
         send_word(make_word(stamp, a, b));
         if ($urandom_range(0, 199) == 0) begin
            drain();
         end
      end
   endtask

   initial begin
      int phase_window[PHASES];
      int phase_spread[PHASES];
      int phase_level[PHASES];
      int p;
      phase_window = '{3000, 0, 65535, 1, 50, 0, 65535, 500};
      phase_spread = '{200, 0, 4095, 1, 1000, 0, 0, 2000};
      phase_level  = '{2048, 0, 4095, 4095, 1000, 0, 0, 3000};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      steady = 1'b0;
      stamp_now = '0;
      cur_window = WINDOW_RESET;
      cur_spread = 0;
      cur_level = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, timestamps wrapping through zero
      send_word(make_word(32'hFFFF_FF00, 0, 0));
      send_word(make_word(32'hFFFF_FF0A, LEVEL_MAX, LEVEL_MAX));
      send_word(make_word(32'hFFFF_FFFF, 2048, 0));
      send_word(make_word(32'h0000_0005, 1, 0));
      drain();

      // short window: level B at, above and below its threshold, spread
      // equal to threshold, expiry, a stamp going backward, a repeated stamp
      configure(20, 100, 2000);
      send_word(make_word(1000, 500, 1999));
      send_word(make_word(1001, 600, 2000));
      send_word(make_word(1002, 650, 2001));
      send_word(make_word(1003, 600, 2000));
      send_word(make_word(1004, 600, 1999));
      send_word(make_word(1005, 550, 2001));
      send_word(make_word(1030, 600, LEVEL_MAX));
      send_word(make_word(1050, 700, 0));
      send_word(make_word(1010, 700, 0));
      send_word(make_word(1010, 0, LEVEL_MAX));
      drain();

      // zero window with full-scale thresholds
      configure(0, LEVEL_MAX, LEVEL_MAX);
      send_word(make_word(2000, LEVEL_MAX, LEVEL_MAX));
      send_word(make_word(2000, 0, LEVEL_MAX));
      send_word(make_word(2001, 17, LEVEL_MAX - 1));
      send_word(make_word(2001, LEVEL_MAX, 0));
      drain();

      phase_window[5] = $urandom_range(1, 65535);
      phase_spread[5] = $urandom_range(0, LEVEL_MAX);
      phase_level[5] = $urandom_range(0, LEVEL_MAX);
      for (p = 0; p < PHASES; p++) begin
         configure(phase_window[p], phase_spread[p], phase_level[p]);
         // start even phases just short of the timestamp wrap
         if (p % 2 == 0) begin
            stamp_now = 32'hFFFF_FFFF - $urandom_range(0, 200000);
         end else begin
            stamp_now = $urandom();
         end
         random_phase(PHASE_WORDS);
         drain();
      end

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
